@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the RTL of the insertion sort engine.
// Each macro takes a label, the clock, the active-low reset and the terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/isrt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrt_pkg
// Payload types and fixed widths of the insertion sort engine.
// ----------------------------------------------------------------------------
package isrt_pkg;

  localparam int DATA_W = 32;

  // One value of the list to sort
  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     final_item;
  } in_item_t;

  // One value of the sorted list
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_list;
    logic                     overflow;
  } out_item_t;

endpackage

@@ rtl/core/insertion_sort_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Stable insertion sort of signed 32-bit values with a list readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one signed value per
//   transfer; final_item marks the last value of a list. Result channel
//   (out_valid/out_ready/out_data) returns the list in ascending order,
//   equal values in arrival order, end_of_list on the last value and
//   overflow on every value if more than DEPTH values arrived.
//   Insertion: into an empty store the value is written straight to the
//   bottom slot and into a full store it is dropped, both from idle; else
//   it walks down from the top entry past every entry greater than it. One
//   compare-and-shift step against the single store RAM runs per cycle.
//   Readout passes each value through the registered RAM read and the output
//   register, and reads the next only after it is taken, however long a stall.
//   in_ready is low while an insertion or a readout is in progress.
//   Reset clears the count, the overflow flag and out_valid; store contents
//   are not cleared and are never read before being written.
//   A stalled receiver holds out_data steady; nothing is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module insertion_sort_engine
  import isrt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_PLACE  = 6'b000100,
    ST_OUT_RD = 6'b001000,
    ST_OUT_LD = 6'b010000,
    ST_OUT_WT = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     dropped_r, dropped_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     last_r, last_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_val;
  logic                     idx_is_last;

  // Sorted store
  isrt_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_val      = $signed(ram_rdata);
  assign idx_is_last = (CW'(idx_r) == count_r - CW'(1));

  // Sequencer: walk the store downward, shifting larger entries up one slot, then read the list out
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = val_r;
    ram_raddr     = '0;
    in_ready      = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_valid) begin
          if (count_r == CW'(DEPTH)) begin
            // store full: drop the value
            dropped_nxt = 1'b1;
            if (in_data.final_item) begin
              state_nxt = ST_OUT_RD;
            end
          end else if (count_r == '0) begin
            // empty store: write straight to the bottom slot
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_data.sample;
            count_nxt = CW'(1);
            if (in_data.final_item) begin
              state_nxt = ST_OUT_RD;
            end
          end else begin
            // start the walk at the top entry
            ram_raddr = count_r[AW-1:0] - AW'(1);
            pos_nxt   = count_r[AW-1:0];
            val_nxt   = in_data.sample;
            last_nxt  = in_data.final_item;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        ram_we = 1'b1;
        if (rd_val > val_r) begin
          // shift the larger entry up and advance downward
          ram_waddr = pos_r;
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - AW'(1);
          if (pos_r == AW'(1)) begin
            state_nxt = ST_PLACE;
          end else begin
            ram_raddr = pos_r - AW'(2);
          end
        end else begin
          // entry is less or equal: new value goes just above it
          ram_waddr = pos_r;
          ram_wdata = val_r;
          count_nxt = count_r + CW'(1);
          state_nxt = last_r ? ST_OUT_RD : ST_IDLE;
        end
      end

      ST_PLACE: begin
        // every entry was larger: place at the bottom
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = last_r ? ST_OUT_RD : ST_IDLE;
      end

      ST_OUT_RD: begin
        ram_raddr = idx_r;
        state_nxt = ST_OUT_LD;
      end

      ST_OUT_LD: begin
        // load the output register from the store read
        out_data_nxt.sorted_value = rd_val;
        out_data_nxt.end_of_list  = idx_is_last;
        out_data_nxt.overflow     = dropped_r;
        out_valid_nxt             = 1'b1;
        state_nxt                 = ST_OUT_WT;
      end

      ST_OUT_WT: begin
        // hold until the transfer, then advance or finish the list
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_data_r.end_of_list) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `ASSERT_IMPLY(a_ready_excl, clk, rst_n, in_ready, !out_valid_r)
  `ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `ASSERT_IMPLY(a_scan_pos, clk, rst_n, state_r == ST_SCAN, pos_r != '0)
  `ASSERT_NEXT(a_list_clear, clk, rst_n,
               out_valid_r && out_ready && out_data_r.end_of_list,
               count_r == '0 && !dropped_r && state_r == ST_IDLE)

endmodule

@@ rtl/core/isrt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module isrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
